// ----- hw/rtl/dlss_pkg.sv -----
// Package with the types and constants of the door latch servo sequencer.
`timescale 1ns / 1ps

package dlss_pkg;

    localparam logic [7:0]  ANGLE_MAX         = 8'd180;
    localparam logic [7:0]  CLOSED_ANGLE_RST  = 8'd90;
    localparam logic [7:0]  OPEN_ANGLE_RST    = 8'd0;
    localparam logic [15:0] DEFAULT_HOLD_RST  = 16'd5000;
    localparam logic [7:0]  STEP_MS_RST       = 8'd15;
    localparam logic [7:0]  TICKS_SAT         = 8'd255;

    localparam logic [1:0] REG_OPEN_ANGLE    = 2'd0;
    localparam logic [1:0] REG_CLOSED_ANGLE  = 2'd1;
    localparam logic [1:0] REG_DEFAULT_HOLD  = 2'd2;
    localparam logic [1:0] REG_STEP_MS       = 2'd3;

    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_OPEN    = 3'd1,
        ACT_CLOSE   = 3'd2,
        ACT_ASSERT  = 3'd3,
        ACT_RELEASE = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        PH_LOCKED  = 2'd0,
        PH_OPENING = 2'd1,
        PH_OPEN    = 2'd2,
        PH_CLOSING = 2'd3
    } t_phase;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] duration_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  door_state;
        logic [7:0]  servo_angle;
        logic [15:0] hold_remaining_ms;
        logic        record_trigger;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  open_angle;
        logic [7:0]  closed_angle;
        logic [15:0] default_hold_ms;
        logic [7:0]  step_ms;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  angle_now;
        logic [7:0]  angle_goal;
        t_phase      phase;
        logic [7:0]  ticks_since_step;
        logic [15:0] hold_length;
        logic        hold_armed;
        logic [15:0] hold_left;
        logic        pulse_active;
        logic [15:0] pulse_left;
    } t_seq_state;

endpackage

// ----- hw/rtl/dlss_core.sv -----
// Sequencer state registers and the single-pass update for one event.
`timescale 1ns / 1ps

module dlss_core
    import dlss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_go,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    t_seq_state r_state;
    t_seq_state n_state;
    logic       just_armed;
    logic [7:0] angle_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.angle_now        <= CLOSED_ANGLE_RST;
            r_state.angle_goal       <= CLOSED_ANGLE_RST;
            r_state.phase            <= PH_LOCKED;
            r_state.ticks_since_step <= TICKS_SAT;
            r_state.hold_length      <= '0;
            r_state.hold_armed       <= 1'b0;
            r_state.hold_left        <= '0;
            r_state.pulse_active     <= 1'b0;
            r_state.pulse_left       <= '0;
        end else if (i_go) begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        just_armed = 1'b0;
        angle_step = (r_state.angle_goal > r_state.angle_now) ?
                     r_state.angle_now + 8'd1 : r_state.angle_now - 8'd1;
        case (i_item.action)
            ACT_TICK: begin
                if (n_state.ticks_since_step != TICKS_SAT) begin
                    n_state.ticks_since_step = n_state.ticks_since_step + 8'd1;
                end
                if (n_state.pulse_active) begin
                    if (n_state.pulse_left != 16'd0) begin
                        n_state.pulse_left = n_state.pulse_left - 16'd1;
                    end
                    if (n_state.pulse_left == 16'd0) begin
                        n_state.pulse_active = 1'b0;
                    end
                end
                if (n_state.angle_now != n_state.angle_goal) begin
                    if (n_state.ticks_since_step >= i_cfg.step_ms) begin
                        n_state.ticks_since_step = '0;
                        n_state.angle_now        = angle_step;
                        if (angle_step == n_state.angle_goal) begin
                            if (n_state.phase == PH_OPENING) begin
                                n_state.phase      = PH_OPEN;
                                n_state.hold_armed = 1'b1;
                                n_state.hold_left  = n_state.hold_length;
                            end else if (n_state.phase == PH_CLOSING) begin
                                n_state.phase = PH_LOCKED;
                            end
                        end
                    end
                end else begin
                    if (n_state.phase == PH_OPENING) begin
                        n_state.phase      = PH_OPEN;
                        n_state.hold_armed = 1'b1;
                        n_state.hold_left  = n_state.hold_length;
                        just_armed         = 1'b1;
                    end else if (n_state.phase == PH_CLOSING) begin
                        n_state.phase = PH_LOCKED;
                    end
                    if (n_state.phase == PH_OPEN && n_state.hold_armed) begin
                        if (!just_armed && n_state.hold_left != 16'd0) begin
                            n_state.hold_left = n_state.hold_left - 16'd1;
                        end
                        if (n_state.hold_left == 16'd0) begin
                            n_state.angle_goal = i_cfg.closed_angle;
                            n_state.hold_armed = 1'b0;
                            n_state.hold_left  = '0;
                            n_state.phase      = PH_CLOSING;
                        end
                    end
                end
            end
            ACT_OPEN: begin
                n_state.angle_goal  = i_cfg.open_angle;
                n_state.hold_length = (i_item.duration_ms != 16'd0) ?
                                      i_item.duration_ms : i_cfg.default_hold_ms;
                n_state.hold_armed  = 1'b0;
                n_state.hold_left   = '0;
                n_state.phase       = PH_OPENING;
            end
            ACT_CLOSE: begin
                n_state.angle_goal = i_cfg.closed_angle;
                n_state.hold_armed = 1'b0;
                n_state.hold_left  = '0;
                n_state.phase      = PH_CLOSING;
            end
            ACT_ASSERT: begin
                n_state.pulse_active = 1'b1;
                if (i_item.duration_ms > n_state.pulse_left) begin
                    n_state.pulse_left = i_item.duration_ms;
                end
            end
            ACT_RELEASE: begin
                n_state.pulse_active = 1'b0;
                n_state.pulse_left   = '0;
            end
            default: begin
            end
        endcase
    end

    assign o_result.door_state        = n_state.phase;
    assign o_result.servo_angle       = n_state.angle_now;
    assign o_result.hold_remaining_ms = n_state.hold_armed ? n_state.hold_left : 16'd0;
    assign o_result.record_trigger    = n_state.pulse_active;

    // The hold countdown only runs while the door stands open.
    a_armed_only_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.hold_armed |-> r_state.phase == PH_OPEN)
        else $error("hold armed outside the open phase");

    // An idle pulse never keeps time left over.
    a_pulse_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.pulse_active |-> r_state.pulse_left == 16'd0)
        else $error("pulse time left while the pulse is inactive");

    // Locked and open are resting phases, so the servo must be at its goal.
    a_rest_at_goal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_LOCKED || r_state.phase == PH_OPEN)
        |-> r_state.angle_now == r_state.angle_goal)
        else $error("resting phase with the servo away from its goal");

    // The servo moves by at most one degree per event.
    a_single_degree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_state.angle_now != $past(r_state.angle_now)
        |-> (r_state.angle_now == $past(r_state.angle_now) + 8'd1
          || r_state.angle_now == $past(r_state.angle_now) - 8'd1))
        else $error("servo angle jumped by more than one degree");

endmodule

// ----- hw/rtl/door_latch_servo_sequencer.sv -----
// Top level of the door latch servo sequencer: register port, input and result stages.
`timescale 1ns / 1ps

// Each input beat carries one event (a millisecond tick or a command) and produces exactly
// one result beat with the door phase, servo angle, remaining hold time and record trigger
// level after that event. While the output is free, the block takes one beat per
// clock cycle: the whole state update is a single pass of logic between the input
// register and the result register. With the output free, a result becomes valid at the
// clock edge after the one that accepts its input beat.
// Configuration registers sit at byte addresses 0, 4, 8 and 12. The user must write them
// only while no event is in flight; the block itself does not enforce this.

module door_latch_servo_sequencer
    import dlss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      go;
    logic      cfg_write;
    logic [7:0] wr_angle;
    t_out_item result;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign wr_angle  = (pwdata[7:0] > ANGLE_MAX) ? ANGLE_MAX : pwdata[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_angle      <= OPEN_ANGLE_RST;
            r_cfg.closed_angle    <= CLOSED_ANGLE_RST;
            r_cfg.default_hold_ms <= DEFAULT_HOLD_RST;
            r_cfg.step_ms         <= STEP_MS_RST;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_OPEN_ANGLE:   r_cfg.open_angle      <= wr_angle;
                REG_CLOSED_ANGLE: r_cfg.closed_angle    <= wr_angle;
                REG_DEFAULT_HOLD: r_cfg.default_hold_ms <= pwdata[15:0];
                REG_STEP_MS:      r_cfg.step_ms         <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_OPEN_ANGLE:   prdata = {24'd0, r_cfg.open_angle};
            REG_CLOSED_ANGLE: prdata = {24'd0, r_cfg.closed_angle};
            REG_DEFAULT_HOLD: prdata = {16'd0, r_cfg.default_hold_ms};
            REG_STEP_MS:      prdata = {24'd0, r_cfg.step_ms};
            default:          prdata = '0;
        endcase
    end

    // The event in the input register is processed whenever the result register is free
    // or being emptied in the same cycle.
    assign go         = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    dlss_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench of the door latch servo sequencer with random events and settings.
`timescale 1ns / 1ps

module tb;
    import dlss_pkg::*;

    localparam logic [2:0] ACT_RSVD_LO   = 3'd5;
    localparam logic [2:0] ACT_RSVD_HI   = 3'd7;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         LONG_HOLD_OFF = 300;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    t_cfg       latch_cfg;
    t_seq_state latch_st;
    t_in_item   event_q[$];
    t_out_item  status_q[$];

    int send_idle_pct = 25;
    int recv_idle_pct = 25;
    bit hold_off_req  = 1'b0;
    bit hold_off_ack  = 1'b0;
    int hold_off_left = 0;
    int mismatch_cnt  = 0;
    int cycle_cnt     = 0;

    door_latch_servo_sequencer DUT (.*);

    always #5 i_clk = ~i_clk;

    function automatic void latch_arm();
        latch_st.phase      = PH_OPEN;
        latch_st.hold_armed = 1'b1;
        latch_st.hold_left  = latch_st.hold_length;
    endfunction

    function automatic void latch_begin_close();
        latch_st.angle_goal = latch_cfg.closed_angle;
        latch_st.hold_armed = 1'b0;
        latch_st.hold_left  = '0;
        latch_st.phase      = PH_CLOSING;
    endfunction

    function automatic t_out_item latch_step(t_in_item ev);
        t_out_item res;
        logic      just_armed;
        just_armed = 1'b0;
        case (ev.action)
            ACT_TICK: begin
                if (latch_st.ticks_since_step != TICKS_SAT)
                    latch_st.ticks_since_step = latch_st.ticks_since_step + 8'd1;
                if (latch_st.pulse_active) begin
                    if (latch_st.pulse_left != 0)
                        latch_st.pulse_left = latch_st.pulse_left - 16'd1;
                    if (latch_st.pulse_left == 0)
                        latch_st.pulse_active = 1'b0;
                end
                if (latch_st.angle_now != latch_st.angle_goal) begin
                    if (latch_st.ticks_since_step >= latch_cfg.step_ms) begin
                        latch_st.ticks_since_step = '0;
                        if (latch_st.angle_goal > latch_st.angle_now)
                            latch_st.angle_now = latch_st.angle_now + 8'd1;
                        else
                            latch_st.angle_now = latch_st.angle_now - 8'd1;
                        if (latch_st.angle_now == latch_st.angle_goal) begin
                            if (latch_st.phase == PH_OPENING)
                                latch_arm();
                            else if (latch_st.phase == PH_CLOSING)
                                latch_st.phase = PH_LOCKED;
                        end
                    end
                end else begin
                    if (latch_st.phase == PH_OPENING) begin
                        latch_arm();
                        just_armed = 1'b1;
                    end else if (latch_st.phase == PH_CLOSING) begin
                        latch_st.phase = PH_LOCKED;
                    end
                    if (latch_st.phase == PH_OPEN && latch_st.hold_armed) begin
                        if (!just_armed && latch_st.hold_left != 0)
                            latch_st.hold_left = latch_st.hold_left - 16'd1;
                        if (latch_st.hold_left == 0)
                            latch_begin_close();
                    end
                end
            end
            ACT_OPEN: begin
                latch_st.angle_goal  = latch_cfg.open_angle;
                latch_st.hold_length = (ev.duration_ms != 0) ? ev.duration_ms
                                                             : latch_cfg.default_hold_ms;
                latch_st.hold_armed  = 1'b0;
                latch_st.hold_left   = '0;
                latch_st.phase       = PH_OPENING;
            end
            ACT_CLOSE: begin
                latch_begin_close();
            end
            ACT_ASSERT: begin
                latch_st.pulse_active = 1'b1;
                if (ev.duration_ms > latch_st.pulse_left)
                    latch_st.pulse_left = ev.duration_ms;
            end
            ACT_RELEASE: begin
                latch_st.pulse_active = 1'b0;
                latch_st.pulse_left   = '0;
            end
            default: begin
            end
        endcase
        res.door_state        = latch_st.phase;
        res.servo_angle       = latch_st.angle_now;
        res.hold_remaining_ms = latch_st.hold_armed ? latch_st.hold_left : 16'd0;
        res.record_trigger    = latch_st.pulse_active;
        return res;
    endfunction

    function automatic t_in_item door_event(logic [2:0] act, logic [15:0] dur);
        t_in_item ev;
        ev.action      = act;
        ev.duration_ms = dur;
        return ev;
    endfunction

    function automatic t_in_item random_event(int tick_pct);
        t_in_item ev;
        int       pick;
        int       span;
        ev.action      = ACT_TICK;
        ev.duration_ms = 16'($urandom);
        pick = $urandom_range(99);
        if (pick >= tick_pct) begin
            pick = $urandom_range(99);
            if (pick < 30)
                ev.action = ACT_OPEN;
            else if (pick < 48)
                ev.action = ACT_CLOSE;
            else if (pick < 72)
                ev.action = ACT_ASSERT;
            else if (pick < 86)
                ev.action = ACT_RELEASE;
            else
                ev.action = 3'($urandom_range(ACT_RSVD_HI, ACT_RSVD_LO));
            span = $urandom_range(9);
            if (span == 0)
                ev.duration_ms = '0;
            else if (span < 8)
                ev.duration_ms = 16'($urandom_range(25, 1));
        end
        return ev;
    endfunction

    function automatic int angle_near(int base, int span);
        int a;
        a = int'($urandom_range(2 * span));
        a = base + a - span;
        return (a < 0) ? 0 : (a > int'(ANGLE_MAX)) ? int'(ANGLE_MAX) : a;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        logic [7:0] low;
        low = value[7:0];
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_OPEN_ANGLE:   latch_cfg.open_angle      = (low > ANGLE_MAX) ? ANGLE_MAX : low;
            REG_CLOSED_ANGLE: latch_cfg.closed_angle    = (low > ANGLE_MAX) ? ANGLE_MAX : low;
            REG_DEFAULT_HOLD: latch_cfg.default_hold_ms = value[15:0];
            REG_STEP_MS:      latch_cfg.step_ms         = low;
            default: begin
            end
        endcase
    endtask

    task automatic write_settings(int open_deg, int closed_deg, int hold_ms, int step);
        logic [31:0] junk;
        junk = $urandom_range(1) ? $urandom : 32'd0;
        write_reg(REG_OPEN_ANGLE, (junk & 32'hFFFF_FF00) | 32'(open_deg));
        write_reg(REG_CLOSED_ANGLE, (junk & 32'hFFFF_FF00) | 32'(closed_deg));
        write_reg(REG_DEFAULT_HOLD, (junk & 32'hFFFF_0000) | 32'(hold_ms));
        write_reg(REG_STEP_MS, (junk & 32'hFFFF_FF00) | 32'(step));
    endtask

    task automatic wait_drained();
        while (event_q.size() != 0 || i_in_valid || status_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Driver: the prediction is made at the edge where the beat is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                status_q.push_back(latch_step(i_in_item));
            if (!i_in_valid || o_in_ready) begin
                if (event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= event_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_off_left != 0) begin
            i_out_ready   <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end else if (hold_off_req != hold_off_ack) begin
            i_out_ready   <= 1'b0;
            hold_off_ack  <= hold_off_req;
            hold_off_left <= LONG_HOLD_OFF;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (status_q.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("Unexpected result beat: %h", o_out_item);
                mismatch_cnt++;
            end else begin
                want = status_q.pop_front();
                if (o_out_item.door_state !== want.door_state
                        || o_out_item.servo_angle !== want.servo_angle
                        || o_out_item.hold_remaining_ms !== want.hold_remaining_ms
                        || o_out_item.record_trigger !== want.record_trigger) begin
                    if (mismatch_cnt < 10)
                        $display("Mismatch: expected state %0d angle %0d hold %0d trig %0b, %s",
                                 want.door_state, want.servo_angle, want.hold_remaining_ms,
                                 want.record_trigger,
                                 $sformatf("got state %0d angle %0d hold %0d trig %0b",
                                           o_out_item.door_state, o_out_item.servo_angle,
                                           o_out_item.hold_remaining_ms,
                                           o_out_item.record_trigger));
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int open_deg;
        int closed_deg;
        int step;
        latch_cfg.open_angle         = OPEN_ANGLE_RST;
        latch_cfg.closed_angle       = CLOSED_ANGLE_RST;
        latch_cfg.default_hold_ms    = DEFAULT_HOLD_RST;
        latch_cfg.step_ms            = STEP_MS_RST;
        latch_st.angle_now           = CLOSED_ANGLE_RST;
        latch_st.angle_goal          = CLOSED_ANGLE_RST;
        latch_st.phase               = PH_LOCKED;
        latch_st.ticks_since_step    = TICKS_SAT;
        latch_st.hold_length         = '0;
        latch_st.hold_armed          = 1'b0;
        latch_st.hold_left           = '0;
        latch_st.pulse_active        = 1'b0;
        latch_st.pulse_left          = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        event_q.push_back(door_event(ACT_TICK, 16'hFFFF));
        event_q.push_back(door_event(ACT_TICK, 16'h0000));
        wait_drained();

        // Zero default hold, fast steps, and a short travel between the two angles.
        write_settings(88, 90, 0, 0);
        event_q.push_back(door_event(ACT_TICK, 16'd0));
        event_q.push_back(door_event(ACT_RSVD_LO, 16'hFFFF));
        event_q.push_back(door_event(ACT_RSVD_LO + 3'd1, 16'h0000));
        event_q.push_back(door_event(ACT_RSVD_HI, 16'h5555));
        event_q.push_back(door_event(ACT_ASSERT, 16'd0));
        event_q.push_back(door_event(ACT_TICK, 16'hAAAA));
        event_q.push_back(door_event(ACT_ASSERT, 16'hFFFF));
        event_q.push_back(door_event(ACT_ASSERT, 16'd100));
        event_q.push_back(door_event(ACT_TICK, 16'd0));
        event_q.push_back(door_event(ACT_RELEASE, 16'hFFFF));
        event_q.push_back(door_event(ACT_OPEN, 16'd0));
        repeat (5) event_q.push_back(door_event(ACT_TICK, 16'd0));
        event_q.push_back(door_event(ACT_OPEN, 16'hFFFF));
        event_q.push_back(door_event(ACT_TICK, 16'd0));
        event_q.push_back(door_event(ACT_CLOSE, 16'd0));
        event_q.push_back(door_event(ACT_TICK, 16'd0));
        event_q.push_back(door_event(ACT_OPEN, 16'd3));
        repeat (6) event_q.push_back(door_event(ACT_TICK, 16'd0));
        wait_drained();

        // Open and closed angles at the two ends of the angle range.
        write_settings(255, 0, 5, 0);
        event_q.push_back(door_event(ACT_OPEN, 16'd0));
        repeat (230) event_q.push_back(random_event(97));
        wait_drained();

        write_settings(0, 180, 65535, 255);
        repeat (60) event_q.push_back(random_event(85));
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            step       = (ph == 4) ? 0 : $urandom_range(3);
            closed_deg = angle_near(latch_st.angle_now, 4);
            open_deg   = (ph == 4) ? $urandom_range(255) : angle_near(latch_st.angle_now, 6);
            write_settings(open_deg, closed_deg, $urandom_range(12), step);
            send_idle_pct = (ph == 3) ? 0 : 25;
            recv_idle_pct = (ph == 3) ? 0 : 25;
            if (ph == 1)
                hold_off_req = ~hold_off_req;
            repeat (100) event_q.push_back(random_event(75));
            wait_drained();
        end

        repeat (20) @(negedge i_clk);
        if (mismatch_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/dlss_pkg.sv
hw/rtl/dlss_core.sv
hw/rtl/door_latch_servo_sequencer.sv
tb/sv/tb.sv
